/* src/rdm_pkg.sv */
// Shared types, codes and constants of the RDM discovery responder.
`timescale 1ns / 1ps

package rdm_pkg;

    // Request operation codes as carried in the input tuser.
    typedef enum logic [1:0] {
        OP_DUB    = 2'd0,
        OP_MUTE   = 2'd1,
        OP_UNMUTE = 2'd2,
        OP_OTHER  = 2'd3
    } op_t;

    // Result kinds as carried in the output tuser.
    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DISC = 2'd1,
        KIND_ACK  = 2'd2
    } kind_t;

    // One classified request waiting for the back end.
    typedef struct packed {
        kind_t kind;
        logic  subdev;
    } rdm_job_t;

    // Configuration register indexes.
    localparam logic REG_OWN_UID = 1'b0;
    localparam logic REG_HAS_SUB = 1'b1;

    localparam int          UID_W          = 48;
    localparam int          CFG_DATA_W     = 64;
    localparam int          CFG_ADDR_W     = 4;
    localparam int          QUEUE_DEPTH    = 2;
    localparam logic [7:0]  PREAMBLE_BYTE  = 8'hFE;
    localparam logic [4:0]  PREAMBLE_COUNT = 5'd7;
    localparam logic [7:0]  SEPARATOR_BYTE = 8'hAA;
    localparam logic [7:0]  ENC_HI         = 8'hAA;
    localparam logic [7:0]  ENC_LO         = 8'h55;
    localparam logic [7:0]  DUB_LENGTH     = 8'd12;
    localparam logic [15:0] SUBDEVICE_FLAG = 16'h0002;
    localparam logic [4:0]  IDX_UID_FIRST  = 5'd8;
    localparam logic [4:0]  IDX_SUM_FIRST  = 5'd20;
    localparam logic [4:0]  IDX_LAST       = 5'd23;

    // UID byte j, counted from the most significant byte.
    function automatic logic [7:0] uid_byte(input logic [UID_W-1:0] uid,
                                            input logic [2:0] j);
        logic [7:0] b;
        case (j)
            3'd0:    b = uid[47:40];
            3'd1:    b = uid[39:32];
            3'd2:    b = uid[31:24];
            3'd3:    b = uid[23:16];
            3'd4:    b = uid[15:8];
            3'd5:    b = uid[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* src/rdm_front.sv */
// Front end: accepts requests, keeps the mute flag and classifies each request.
`timescale 1ns / 1ps

module rdm_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [1:0]                s_tuser,
    input  logic [111:0]              s_tdata,
    input  logic [rdm_pkg::UID_W-1:0] own_uid,
    input  logic                      has_subdevices,
    input  logic                      q_full,
    output logic                      push,
    output rdm_pkg::rdm_job_t         job
);

    logic                      muted_reg;
    logic                      muted_next;
    rdm_pkg::op_t              op;
    logic [rdm_pkg::UID_W-1:0] lower_uid;
    logic [rdm_pkg::UID_W-1:0] upper_uid;
    logic [7:0]                param_length;
    logic                      is_unicast;
    logic                      in_range;

    // Unpack the request fields.
    assign op           = rdm_pkg::op_t'(s_tuser);
    assign lower_uid    = s_tdata[47:0];
    assign upper_uid    = s_tdata[95:48];
    assign param_length = s_tdata[103:96];
    assign is_unicast   = s_tdata[104];

    assign s_tready = !q_full;
    assign push     = s_tvalid && s_tready;
    assign in_range = (lower_uid <= own_uid) && (own_uid <= upper_uid);

    // Classify the request and work out the new mute flag.
    always_comb
    begin
        muted_next = muted_reg;
        job.kind   = rdm_pkg::KIND_NONE;
        job.subdev = has_subdevices;
        case (op)
            rdm_pkg::OP_DUB:
            begin
                if (!muted_reg && param_length == rdm_pkg::DUB_LENGTH && in_range)
                begin
                    job.kind = rdm_pkg::KIND_DISC;
                end
            end
            rdm_pkg::OP_MUTE, rdm_pkg::OP_UNMUTE:
            begin
                if (param_length == 8'd0)
                begin
                    muted_next = (op == rdm_pkg::OP_MUTE);
                    if (is_unicast)
                    begin
                        job.kind = rdm_pkg::KIND_ACK;
                    end
                end
            end
            default:
            begin
                job.kind = rdm_pkg::KIND_NONE;
            end
        endcase
    end

    // Mute flag changes only when a request is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            muted_reg <= 1'b0;
        end
        else if (push)
        begin
            muted_reg <= muted_next;
        end
    end

endmodule

/* src/rdm_queue.sv */
// Small FIFO of classified requests between the front and back ends.
`timescale 1ns / 1ps

module rdm_queue #(
    parameter int DEPTH = rdm_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rdm_pkg::rdm_job_t push_job,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output rdm_pkg::rdm_job_t head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rdm_pkg::rdm_job_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* src/rdm_back.sv */
// Back end: turns the job at the queue head into result items, one per cycle while out_ready is high.
`timescale 1ns / 1ps

module rdm_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      head_valid,
    input  rdm_pkg::rdm_job_t         head_job,
    input  logic [rdm_pkg::UID_W-1:0] own_uid,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output rdm_pkg::kind_t            out_kind,
    output logic [7:0]                out_byte,
    output logic [15:0]               out_ctrl,
    output logic                      out_last
);

    logic [4:0]  idx_reg;
    logic [4:0]  idx_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [4:0]  uid_pos;
    logic [7:0]  raw_byte;
    logic [7:0]  disc_byte;
    logic        take;

    assign out_valid = head_valid;
    assign out_kind  = head_job.kind;
    assign take      = out_valid && out_ready;
    assign uid_pos   = idx_reg - rdm_pkg::IDX_UID_FIRST;

    // Reply byte for the current position of a discovery reply.
    always_comb
    begin
        if (idx_reg < rdm_pkg::IDX_UID_FIRST)
        begin
            raw_byte = 8'h00;
        end
        else if (idx_reg < rdm_pkg::IDX_SUM_FIRST)
        begin
            raw_byte = rdm_pkg::uid_byte(own_uid, uid_pos[3:1]);
        end
        else if (idx_reg[1])
        begin
            raw_byte = sum_reg[7:0];
        end
        else
        begin
            raw_byte = sum_reg[15:8];
        end

        if (idx_reg < rdm_pkg::PREAMBLE_COUNT)
        begin
            disc_byte = rdm_pkg::PREAMBLE_BYTE;
        end
        else if (idx_reg < rdm_pkg::IDX_UID_FIRST)
        begin
            disc_byte = rdm_pkg::SEPARATOR_BYTE;
        end
        else if (idx_reg[0])
        begin
            disc_byte = raw_byte | rdm_pkg::ENC_LO;
        end
        else
        begin
            disc_byte = raw_byte | rdm_pkg::ENC_HI;
        end
    end

    // Result fields by kind.
    always_comb
    begin
        out_byte = 8'h00;
        out_ctrl = 16'h0000;
        out_last = 1'b1;
        case (head_job.kind)
            rdm_pkg::KIND_DISC:
            begin
                out_byte = disc_byte;
                out_last = (idx_reg == rdm_pkg::IDX_LAST);
            end
            rdm_pkg::KIND_ACK:
            begin
                out_ctrl = head_job.subdev ? rdm_pkg::SUBDEVICE_FLAG : 16'h0000;
            end
            default:
            begin
                out_last = 1'b1;
            end
        endcase
    end

    // Byte counter advances on each taken item, the checksum on each taken UID byte.
    always_comb
    begin
        idx_next = idx_reg;
        sum_next = sum_reg;
        pop      = take && out_last;
        if (take)
        begin
            if (out_last)
            begin
                idx_next = 5'd0;
            end
            else
            begin
                idx_next = idx_reg + 5'd1;
            end
            if (idx_reg < rdm_pkg::IDX_UID_FIRST)
            begin
                sum_next = 16'h0000;
            end
            else if (idx_reg < rdm_pkg::IDX_SUM_FIRST)
            begin
                sum_next = sum_reg + {8'h00, disc_byte};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 5'd0;
            sum_reg <= 16'h0000;
        end
        else
        begin
            idx_reg <= idx_next;
            sum_reg <= sum_next;
        end
    end

endmodule

/* src/rdm_discovery_responder.sv */
// Top level of the RDM discovery responder: configuration port and stream wiring.
`timescale 1ns / 1ps

// Discovery side of an RDM responder. Each input item is one request
// (unique branch, mute, un-mute or other) and yields one or more result
// items, the final one marked by tlast. A matching unique-branch request
// yields the 24-byte encoded discovery reply, one byte per cycle while
// m_tready is high; every other request yields a single item. The front
// end classifies a request and updates the mute flag in the cycle it is
// taken and accepts one item per cycle as long as the request queue
// (QUEUE_DEPTH entries) has room, so requests keep arriving while a reply
// is being sent. Configuration (own UID at byte address 0, sub-device flag
// at address 8) is to be written only while the block is idle.

module rdm_discovery_responder #(
    parameter int QUEUE_DEPTH = rdm_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // APB-style configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rdm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [rdm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [rdm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    // Request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [1:0]                     s_tuser,  // op
    // lower_uid [47:0], upper_uid [95:48], param_length [103:96], is_unicast [104]
    input  logic [111:0]                   s_tdata,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [1:0]                     m_tuser,  // kind
    output logic [23:0]                    m_tdata,  // reply_byte [7:0], control_word [23:8]
    output logic                           m_tlast
);

    logic [rdm_pkg::UID_W-1:0] own_uid_reg;
    logic                      has_sub_reg;
    logic                      cfg_write;
    logic                      q_full;
    logic                      push;
    logic                      pop;
    logic                      head_valid;
    rdm_pkg::rdm_job_t         push_job;
    rdm_pkg::rdm_job_t         head_job;
    rdm_pkg::kind_t            out_kind;
    logic [7:0]                out_byte;
    logic [15:0]               out_ctrl;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_uid_reg <= '0;
            has_sub_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            if (paddr[3] == rdm_pkg::REG_OWN_UID)
            begin
                own_uid_reg <= pwdata[rdm_pkg::UID_W-1:0];
            end
            else
            begin
                has_sub_reg <= pwdata[0];
            end
        end
    end

    // Register read-back.
    always_comb
    begin
        if (paddr[3] == rdm_pkg::REG_OWN_UID)
        begin
            prdata = {{(rdm_pkg::CFG_DATA_W - rdm_pkg::UID_W){1'b0}}, own_uid_reg};
        end
        else
        begin
            prdata = {{(rdm_pkg::CFG_DATA_W - 1){1'b0}}, has_sub_reg};
        end
    end

    rdm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tuser        (s_tuser),
        .s_tdata        (s_tdata),
        .own_uid        (own_uid_reg),
        .has_subdevices (has_sub_reg),
        .q_full         (q_full),
        .push           (push),
        .job            (push_job)
    );

    rdm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    rdm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .own_uid    (own_uid_reg),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_kind   (out_kind),
        .out_byte   (out_byte),
        .out_ctrl   (out_ctrl),
        .out_last   (m_tlast)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {out_ctrl, out_byte};

endmodule

/* src/rdm_checker.sv */
// Port-level assertions for the RDM discovery responder, bound to the top level.
`timescale 1ns / 1ps

module rdm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [1:0]  m_tuser,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // A discovery reply runs without gaps until its final byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser == rdm_pkg::KIND_DISC && !m_tlast
        |=> m_tvalid && m_tuser == rdm_pkg::KIND_DISC)
    else $error("discovery reply broken off");

    // A no-response item is a single all-zero item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == rdm_pkg::KIND_NONE |-> m_tlast && m_tdata == 24'h0)
    else $error("bad no-response item");

    // An acknowledge is single and carries only the sub-device flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == rdm_pkg::KIND_ACK
        |-> m_tlast && m_tdata[7:0] == 8'h00
            && (m_tdata[23:8] == 16'h0000 || m_tdata[23:8] == rdm_pkg::SUBDEVICE_FLAG))
    else $error("bad mute acknowledge");

    // A stalled result item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result item changed");

endmodule

bind rdm_discovery_responder rdm_checker u_rdm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
